>>> rtl/core/sac_pkg.sv
// shared types and constants of the set-associative lru tag store
// no dependencies
`default_nettype none

package sac_pkg;

  // defaults of the top level parameters
  localparam int MaxSetBitsDef = 6;
  localparam int MaxWaysDef    = 8;

  // payload widths
  localparam int AddrW = 64;
  localparam int TagW  = 64;

  // configuration port
  localparam int CfgAddrW     = 2;
  localparam int CfgDataW     = 6;
  localparam int CfgSetBitsW  = 3;
  localparam int CfgOffBitsW  = 6;
  localparam int CfgWaysW     = 4;

  localparam logic [CfgSetBitsW-1:0] SetBitsRst = 3'd4;
  localparam logic [CfgOffBitsW-1:0] OffBitsRst = 6'd4;
  localparam logic [CfgWaysW-1:0]    WaysRst    = 4'd1;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_OFFSET_BITS = 2'd1,
    CFG_WAYS_IN_USE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  // outcome of one set lookup
  typedef struct packed {
    logic hit;
    logic evict;
    logic tag_we;
  } lookup_res_t;

endpackage

`default_nettype wire

>>> rtl/core/set_assoc_lru_cache_tags.sv
// top level of the set-associative tag store with true lru replacement
// depends on sac_pkg, sac_ram and sac_lookup
`default_nettype none

// Tag store of a set-associative cache with true LRU replacement. Each
// transfer on the slave side is one access address; each access yields one
// transfer on the master side carrying hit and eviction flags. The set index
// is the address shifted right by offset_bits and masked to set_bits bits
// (capped at MaxSetBits); the tag is the address shifted right by
// set_bits + offset_bits, zero when that reaches 64. A hit makes the way most
// recent; a miss fills the lowest invalid way in use, else replaces the least
// recent way and flags an eviction. Each set is one row of two synchronous
// rams: tags, and valid bits with per-way recency ranks. An access first
// reads the row, then compares, updates and writes the row back; the next
// access and its read are taken only after the write-back, so one access is
// in flight at a time and no forwarding is involved. The write-back waits
// while the previous result has not been taken. After reset a clearing pass
// zeroes every row of the valid/recency ram, with tready low.
// Configuration writes are taken at any time but must only happen while idle.

module set_assoc_lru_cache_tags #(
  parameter int MaxSetBits = sac_pkg::MaxSetBitsDef,
  parameter int MaxWays    = sac_pkg::MaxWaysDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [sac_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [sac_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // access stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [sac_pkg::AddrW-1:0]     s_axis_tdata,   // [63:0] address
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [7:0]                    m_axis_tdata    // [0] hit, [1] eviction
);
  import sac_pkg::*;

  localparam int NumSets = 1 << MaxSetBits;
  localparam int SetAw   = (MaxSetBits > 0) ? MaxSetBits : 1;
  localparam int RecW    = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int WayCntW = $clog2(MaxWays + 1);
  localparam int NwW     = (WayCntW > CfgWaysW) ? WayCntW : CfgWaysW;
  localparam int SbW     = 4;   // holds set_bits and MaxSetBits
  localparam int TotW    = 7;   // holds set_bits + offset_bits
  localparam int MetaW   = MaxWays * (RecW + 1);

  // configuration registers
  logic [CfgSetBitsW-1:0] set_bits_q;
  logic [CfgOffBitsW-1:0] offset_bits_q;
  logic [CfgWaysW-1:0]    ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q    <= SetBitsRst;
      offset_bits_q <= OffBitsRst;
      ways_q        <= WaysRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_SET_BITS:    set_bits_q    <= cfg_wdata_i[CfgSetBitsW-1:0];
        CFG_OFFSET_BITS: offset_bits_q <= cfg_wdata_i[CfgOffBitsW-1:0];
        CFG_WAYS_IN_USE: ways_q        <= cfg_wdata_i[CfgWaysW-1:0];
        default: ;  // unknown index, ignored
      endcase
    end
  end

  // effective geometry
  logic [SbW-1:0]  sb_ext;
  logic [SbW-1:0]  sb_eff;
  logic [NwW-1:0]  ways_ext;
  logic [NwW-1:0]  nways;
  logic [TotW-1:0] total;

  always_comb begin
    sb_ext   = SbW'(set_bits_q);
    sb_eff   = (sb_ext > SbW'(MaxSetBits)) ? SbW'(MaxSetBits) : sb_ext;
    ways_ext = NwW'(ways_q);
    if (ways_ext == '0) begin
      nways = NwW'(1);
    end else if (ways_ext > NwW'(MaxWays)) begin
      nways = NwW'(MaxWays);
    end else begin
      nways = ways_ext;
    end
    total = TotW'(sb_eff) + TotW'(offset_bits_q);
  end

  // address split for the incoming access
  logic [AddrW-1:0] shifted;
  logic [SetAw-1:0] in_set;
  logic [TagW-1:0]  in_tag;

  always_comb begin
    shifted = s_axis_tdata >> offset_bits_q;
    for (int i = 0; i < SetAw; i++) begin
      in_set[i] = shifted[i] & (SbW'(i) < sb_eff);
    end
    in_tag = (total >= TotW'(AddrW)) ? '0 : TagW'(s_axis_tdata >> total);
  end

  // control
  state_e          state_q, state_d;
  logic [SetAw-1:0] clr_idx_q;
  logic             clr_last;
  logic             s_acc;
  logic             commit;
  logic             clr_we;

  assign clr_last = clr_idx_q == SetAw'(NumSets - 1);
  assign s_acc    = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_last) state_d = ST_IDLE;
      ST_IDLE:   if (s_acc)    state_d = ST_LOOKUP;
      ST_LOOKUP: if (commit)   state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    s_axis_tready = state_q == ST_IDLE;
    clr_we        = state_q == ST_CLEAR;
    // the row is written back when the result register has room
    commit        = (state_q == ST_LOOKUP) && (!m_axis_tvalid || m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (clr_we) begin
        clr_idx_q <= clr_idx_q + SetAw'(1);
      end
    end
  end

  // access being worked on
  logic [SetAw-1:0] req_set_q;
  logic [TagW-1:0]  req_tag_q;

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      req_set_q <= in_set;
      req_tag_q <= in_tag;
    end
  end

  // set rows
  logic [MetaW-1:0]                  meta_rd;
  logic [MetaW-1:0]                  meta_wr;
  logic [MaxWays*TagW-1:0]           tags_rd;
  logic [MaxWays-1:0][TagW-1:0]      tags_new;
  logic [MaxWays-1:0]                valid_row;
  logic [MaxWays-1:0][RecW-1:0]      rec_row;
  logic [MaxWays-1:0]                valid_new;
  logic [MaxWays-1:0][RecW-1:0]      rec_new;
  lookup_res_t                       res;
  logic                              meta_we;
  logic [SetAw-1:0]                  meta_waddr;

  assign valid_row  = meta_rd[MaxWays-1:0];
  assign rec_row    = meta_rd[MetaW-1:MaxWays];
  assign meta_we    = clr_we || commit;
  assign meta_waddr = clr_we ? clr_idx_q : req_set_q;
  assign meta_wr    = clr_we ? '0 : {rec_new, valid_new};

  sac_ram #(
    .Width (MetaW),
    .Depth (NumSets)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wr),
    .re_i    (s_acc),
    .raddr_i (in_set),
    .rdata_o (meta_rd)
  );

  sac_ram #(
    .Width (MaxWays * TagW),
    .Depth (NumSets)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (commit && res.tag_we),
    .waddr_i (req_set_q),
    .wdata_i (tags_new),
    .re_i    (s_acc),
    .raddr_i (in_set),
    .rdata_o (tags_rd)
  );

  sac_lookup #(
    .MaxWays (MaxWays),
    .NwW     (NwW)
  ) u_lookup (
    .valid_i   (valid_row),
    .rec_i     (rec_row),
    .tag_i     (tags_rd),
    .req_tag_i (req_tag_q),
    .nways_i   (nways),
    .valid_o   (valid_new),
    .rec_o     (rec_new),
    .tag_o     (tags_new),
    .res_o     (res)
  );

  // result register, holds while the consumer stalls
  logic m_valid_q, m_valid_d;
  logic hit_q;
  logic evict_q;

  always_comb begin
    m_valid_d = m_valid_q;
    if (commit) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      hit_q   <= res.hit;
      evict_q <= res.evict;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, evict_q, hit_q};

  // checks
  // only one access in flight: nothing is taken in the cycle after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("access accepted while another is in flight");

  // a write-back always leaves a result waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> m_axis_tvalid)
    else $error("write-back without a result");

  // an access never hits and evicts at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("hit and eviction both set");

  // row writes never overlap a row read of a new access
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    meta_we |-> !s_acc)
    else $error("row write overlaps a read");

endmodule

`default_nettype wire

>>> rtl/core/sac_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module sac_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/sac_lookup.sv
// tag compare, victim choice and recency update for one set row
// depends on sac_pkg
`default_nettype none

module sac_lookup #(
  parameter int MaxWays = 8,
  parameter int NwW     = 5,
  localparam int RecW   = (MaxWays > 1) ? $clog2(MaxWays) : 1,
  localparam int WayW   = (MaxWays > 1) ? $clog2(MaxWays) : 1
) (
  input  wire logic [MaxWays-1:0]                       valid_i,
  input  wire logic [MaxWays-1:0][RecW-1:0]             rec_i,
  input  wire logic [MaxWays-1:0][sac_pkg::TagW-1:0]    tag_i,
  input  wire logic [sac_pkg::TagW-1:0]                 req_tag_i,
  input  wire logic [NwW-1:0]                           nways_i,
  output logic      [MaxWays-1:0]                       valid_o,
  output logic      [MaxWays-1:0][RecW-1:0]             rec_o,
  output logic      [MaxWays-1:0][sac_pkg::TagW-1:0]    tag_o,
  output sac_pkg::lookup_res_t                          res_o
);
  import sac_pkg::*;

  logic [MaxWays-1:0] in_use;
  logic [MaxWays-1:0] match;
  logic [MaxWays-1:0] free;
  logic               hit;
  logic               have_free;
  logic               fill;
  logic [WayW-1:0]    hit_way;
  logic [WayW-1:0]    free_way;
  logic [WayW-1:0]    victim;
  logic [WayW-1:0]    sel_way;
  logic [RecW-1:0]    old_rank;
  logic [NwW-1:0]     count;

  always_comb begin
    for (int i = 0; i < MaxWays; i++) begin
      in_use[i] = NwW'(i) < nways_i;
      match[i]  = in_use[i] && valid_i[i] && (tag_i[i] == req_tag_i);
      free[i]   = in_use[i] && !valid_i[i];
    end
    hit       = |match;
    have_free = |free;

    // lowest matching and lowest free way
    hit_way  = '0;
    free_way = '0;
    for (int i = MaxWays - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_way = WayW'(i);
      end
      if (free[i]) begin
        free_way = WayW'(i);
      end
    end

    // lowest rank wins, ties go to the lowest way
    victim = '0;
    for (int i = 1; i < MaxWays; i++) begin
      if (in_use[i] && (rec_i[i] < rec_i[victim])) begin
        victim = WayW'(i);
      end
    end

    fill = !hit && have_free;
    priority if (hit) begin
      sel_way = hit_way;
    end else if (have_free) begin
      sel_way = free_way;
    end else begin
      sel_way = victim;
    end

    valid_o = valid_i;
    if (fill) begin
      valid_o[sel_way] = 1'b1;
    end

    count = '0;
    for (int i = 0; i < MaxWays; i++) begin
      count = count + NwW'(valid_o[i] & in_use[i]);
    end

    old_rank = rec_i[sel_way];
    rec_o    = rec_i;
    for (int i = 0; i < MaxWays; i++) begin
      if (!fill && in_use[i] && valid_i[i] && (WayW'(i) != sel_way) &&
          (rec_i[i] > old_rank)) begin
        rec_o[i] = rec_i[i] - RecW'(1);
      end
    end
    rec_o[sel_way] = RecW'(count - NwW'(1));

    tag_o          = tag_i;
    tag_o[sel_way] = req_tag_i;

    res_o.hit    = hit;
    res_o.evict  = !hit && !have_free;
    res_o.tag_we = !hit;
  end

endmodule

`default_nettype wire
